FILE: design/hidk_pkg.sv
// ----------------------------------------------------------------------------
// hidk_pkg
// Shared types and constants for the keyboard report to character block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hidk_pkg;

  // report geometry
  localparam int unsigned MAX_REPORT_BYTES = 11;
  localparam logic [7:0]  SHORT_REPORT_LEN = 8'd8;
  localparam logic [7:0]  LONG_REPORT_LEN  = 8'd11;

  // key codes at or above this value have no character
  localparam logic [7:0]  KEY_TABLE_CODES  = 8'd96;

  // handle that carries reports after reset
  localparam logic [15:0] HANDLE_RESET     = 16'h0040;

  // one stored report, byte zero in the low slot
  typedef logic [MAX_REPORT_BYTES-1:0][7:0] report_t;

  // lookup result handed back to the top level
  typedef struct packed {
    logic       emit;
    logic [6:0] char_code;
  } key_lookup_t;

endpackage

FILE: design/hidk_key_lookup.sv
// ----------------------------------------------------------------------------
// hidk_key_lookup
// Maps a key code and modifier to a character and checks the key against
// the key slots of the previous report.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hidk_key_lookup (
  input  logic [7:0]          code,
  input  logic [7:0]          modifier,
  input  logic                wide,
  input  hidk_pkg::report_t   previous_report,
  output hidk_pkg::key_lookup_t result
);

  typedef enum logic [1:0] {
    COL_PLAIN,
    COL_CTRL,
    COL_SHIFT,
    COL_NONE
  } column_t;

  // character table, one column per modifier state
  function automatic logic [6:0] key_char(input column_t col, input logic [6:0] kc);
    logic [6:0] ch;
    logic [6:0] off;
    off = kc - 7'd4;
    ch  = 7'd0;
    if (kc >= 7'd4 && kc <= 7'd29) begin
      case (col)
        COL_PLAIN: ch = 7'h61 + off;
        COL_CTRL:  ch = off + 7'd1;
        COL_SHIFT: ch = 7'h41 + off;
        default:   ch = 7'd0;
      endcase
    end else if (col == COL_PLAIN) begin
      if (kc >= 7'd30 && kc <= 7'd38) begin
        ch = 7'h31 + (kc - 7'd30);
      end else begin
        case (kc)
          7'd39:   ch = 7'h30;
          7'd40:   ch = 7'd13;
          7'd41:   ch = 7'd27;
          7'd42:   ch = 7'd8;
          7'd43:   ch = 7'd9;
          7'd44:   ch = 7'h20;
          7'd45:   ch = 7'h2D;
          7'd46:   ch = 7'h3D;
          7'd47:   ch = 7'h5B;
          7'd48:   ch = 7'h5D;
          7'd49:   ch = 7'h5C;
          7'd51:   ch = 7'h3B;
          7'd52:   ch = 7'h27;
          7'd53:   ch = 7'h60;
          7'd54:   ch = 7'h2C;
          7'd55:   ch = 7'h2E;
          7'd56:   ch = 7'h2F;
          7'd76:   ch = 7'h7F;
          default: ch = 7'd0;
        endcase
      end
    end else if (col == COL_SHIFT) begin
      case (kc)
        7'd30:   ch = 7'h21;
        7'd31:   ch = 7'h40;
        7'd32:   ch = 7'h23;
        7'd33:   ch = 7'h24;
        7'd34:   ch = 7'h25;
        7'd35:   ch = 7'h5E;
        7'd36:   ch = 7'h26;
        7'd37:   ch = 7'h2A;
        7'd38:   ch = 7'h28;
        7'd39:   ch = 7'h29;
        7'd40:   ch = 7'd13;
        7'd41:   ch = 7'd27;
        7'd42:   ch = 7'd8;
        7'd43:   ch = 7'd9;
        7'd44:   ch = 7'h20;
        7'd45:   ch = 7'h5F;
        7'd46:   ch = 7'h2B;
        7'd47:   ch = 7'h7B;
        7'd48:   ch = 7'h7D;
        7'd49:   ch = 7'h7C;
        7'd51:   ch = 7'h3A;
        7'd52:   ch = 7'h22;
        7'd53:   ch = 7'h7E;
        7'd54:   ch = 7'h3C;
        7'd55:   ch = 7'h3E;
        7'd56:   ch = 7'h3F;
        7'd76:   ch = 7'h7F;
        default: ch = 7'd0;
      endcase
    end
    return ch;
  endfunction

  column_t    col;
  logic [6:0] ch;
  logic       seen;

  // modifier to column; ctrl plus shift uses the ctrl column
  always_comb begin
    case (modifier)
      8'd0:    col = COL_PLAIN;
      8'd1:    col = COL_CTRL;
      8'd2:    col = COL_SHIFT;
      8'd3:    col = COL_CTRL;
      default: col = COL_NONE;
    endcase
  end

  // table read, codes past the table give nothing
  always_comb begin
    if (code < hidk_pkg::KEY_TABLE_CODES) begin
      ch = key_char(col, code[6:0]);
    end else begin
      ch = 7'd0;
    end
  end

  // compare against the key slots of the previous report
  always_comb begin
    seen = 1'b0;
    for (int k = 1; k < hidk_pkg::MAX_REPORT_BYTES; k++) begin
      if ((wide || (k >= 2 && k <= 7)) && previous_report[k] == code) begin
        seen = 1'b1;
      end
    end
  end

  assign result.emit      = (ch != 7'd0) && !seen;
  assign result.char_code = ch;

endmodule

FILE: design/hid_report_new_key_to_ascii.sv
// ----------------------------------------------------------------------------
// hid_report_new_key_to_ascii
// Turns keyboard report bytes into characters of newly pressed keys.
// A character appears on the output in the cycle after its byte's
// transfer. Throughput: one report byte per cycle while in_stall is low;
// the slot compares and the table read sit between the input ports and
// the output register. Reset clears the previous report, byte position,
// modifier and output valid, and sets the report handle to 0x0040.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hid_report_new_key_to_ascii (
  input  logic        clk,
  input  logic        rst,
  // configuration write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  // report byte input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] attr_handle,
  input  logic [7:0]  report_length,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  // character output
  output logic        out_valid,
  input  logic        out_stall,
  output logic [6:0]  char_code
);

  logic [15:0]           key_report_handle;
  hidk_pkg::report_t     previous_report;
  hidk_pkg::report_t     previous_report_next;
  hidk_pkg::report_t     pending_report;
  logic [3:0]            byte_position;
  logic [3:0]            byte_position_next;
  logic [7:0]            current_modifier;

  logic                  in_fire;
  logic                  match;
  logic                  wide;
  logic [3:0]            pos_limit;
  logic [3:0]            first_key;
  logic                  write_en;
  logic                  emit;
  hidk_pkg::key_lookup_t lookup;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid && out_stall;
  assign in_fire   = in_valid && !in_stall;

  // report filter and slot geometry
  assign wide      = (report_length == hidk_pkg::LONG_REPORT_LEN);
  assign match     = (attr_handle == key_report_handle) &&
                     (wide || report_length == hidk_pkg::SHORT_REPORT_LEN);
  assign pos_limit = wide ? 4'(hidk_pkg::LONG_REPORT_LEN) : 4'(hidk_pkg::SHORT_REPORT_LEN);
  assign first_key = wide ? 4'd1 : 4'd2;
  assign write_en  = match && (byte_position < pos_limit);

  hidk_key_lookup u_lookup (
    .code            (data_byte),
    .modifier        (current_modifier),
    .wide            (wide),
    .previous_report (previous_report),
    .result          (lookup)
  );

  assign emit = in_fire && write_en && (byte_position >= first_key) &&
                (data_byte != 8'd0) && lookup.emit;

  // next previous report on the last byte: received bytes replace old ones
  always_comb begin
    previous_report_next = previous_report;
    for (int k = 0; k < hidk_pkg::MAX_REPORT_BYTES; k++) begin
      if (4'(k) < byte_position) begin
        previous_report_next[k] = pending_report[k];
      end else if (4'(k) == byte_position && write_en) begin
        previous_report_next[k] = data_byte;
      end
    end
  end

  // byte position update
  always_comb begin
    if (!match || last_byte) begin
      byte_position_next = 4'd0;
    end else if (write_en) begin
      byte_position_next = byte_position + 4'd1;
    end else begin
      byte_position_next = byte_position;
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      key_report_handle <= hidk_pkg::HANDLE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      key_report_handle <= cfg_data;
    end
  end

  // report state
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_report  <= '0;
      byte_position    <= 4'd0;
      current_modifier <= 8'd0;
    end else if (in_fire) begin
      byte_position <= byte_position_next;
      if (write_en && byte_position == 4'd0) begin
        current_modifier <= data_byte;
      end
      if (match && last_byte) begin
        previous_report <= previous_report_next;
      end
    end
  end

  // bytes of the report in progress
  always_ff @(posedge clk) begin
    if (in_fire && write_en) begin
      pending_report[byte_position] <= data_byte;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!in_stall) begin
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      char_code <= lookup.char_code;
    end
  end

`ifndef NO_ASSERTIONS
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    byte_position <= 4'(hidk_pkg::MAX_REPORT_BYTES))
    else $error("byte position past report end");

  a_foreign_resets: assert property (@(posedge clk) disable iff (rst)
    (in_fire && (!match || last_byte)) |=> byte_position == 4'd0)
    else $error("byte position not cleared after foreign or last byte");

  a_char_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> char_code != 7'd0)
    else $error("zero character presented");

  a_out_from_transfer: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_fire))
    else $error("character without an input transfer");
`endif

endmodule

FILE: tb/hid_report_new_key_to_ascii_tb.sv
// ----------------------------------------------------------------------------
// hid_report_new_key_to_ascii_tb
// Self-checking bench for the keyboard report to character block. A short
// table of report bytes exercises the corner cases, then random reports run
// under several handle settings with random idling on both sides. Every
// character transfer is checked against the table or a local decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hid_report_new_key_to_ascii_tb;

  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 5;
  localparam int ITEM_TARGET  = 1400;
  localparam int PHASES       = 6;
  localparam int HOLD_CYCLES  = 200;
  localparam int SETTLE       = 4;
  localparam int IDLE_PCT     = 29;
  localparam int SHOW_LIMIT   = 10;
  localparam int RUN_LIMIT_NS = 4000000;

  // how a table row is checked
  typedef enum logic [1:0] {
    EXP_PREDICT,
    EXP_NONE,
    EXP_CHAR
  } exp_kind_t;

  typedef struct packed {
    logic [15:0] handle;
    logic [7:0]  len;
    logic [7:0]  data;
    logic        last;
    exp_kind_t   kind;
    logic [6:0]  chr;
  } report_row_t;

  localparam logic [15:0] H = hidk_pkg::HANDLE_RESET;
  localparam int DIR_ROWS = 22;

  localparam report_row_t DIRECTED_ROWS [0:DIR_ROWS-1] = '{
    // eight-byte report after reset: reserved byte, extremes, delete key
    {H, 8'd8, 8'h00, 1'b0, EXP_NONE, 7'h00},
    {H, 8'd8, 8'hFF, 1'b0, EXP_NONE, 7'h00},
    {H, 8'd8, 8'h04, 1'b0, EXP_CHAR, 7'h61},
    {H, 8'd8, 8'h1E, 1'b0, EXP_CHAR, 7'h31},
    {H, 8'd8, 8'h00, 1'b0, EXP_NONE, 7'h00},
    {H, 8'd8, 8'h60, 1'b0, EXP_NONE, 7'h00},
    {H, 8'd8, 8'hFF, 1'b0, EXP_NONE, 7'h00},
    {H, 8'd8, 8'h4C, 1'b1, EXP_CHAR, 7'h7F},
    // short eleven-byte report with shift, one key held over
    {H, 8'd11, 8'h02, 1'b0, EXP_PREDICT, 7'h00},
    {H, 8'd11, 8'h04, 1'b0, EXP_PREDICT, 7'h00},
    {H, 8'd11, 8'h05, 1'b0, EXP_PREDICT, 7'h00},
    {H, 8'd11, 8'h2D, 1'b1, EXP_PREDICT, 7'h00},
    // ctrl plus shift falls back to ctrl
    {H, 8'd11, 8'h03, 1'b0, EXP_PREDICT, 7'h00},
    {H, 8'd11, 8'h06, 1'b1, EXP_PREDICT, 7'h00},
    // modifier out of range
    {H, 8'd11, 8'h04, 1'b0, EXP_NONE, 7'h00},
    {H, 8'd11, 8'h07, 1'b1, EXP_NONE, 7'h00},
    // foreign handle and unsupported lengths
    {16'hFFFF, 8'd8, 8'h04, 1'b1, EXP_NONE, 7'h00},
    {H, 8'd0, 8'h04, 1'b0, EXP_NONE, 7'h00},
    {H, 8'hFF, 8'h04, 1'b1, EXP_NONE, 7'h00},
    // length switching inside one report
    {H, 8'd11, 8'h00, 1'b0, EXP_PREDICT, 7'h00},
    {H, 8'd8, 8'h08, 1'b0, EXP_PREDICT, 7'h00},
    {H, 8'd11, 8'h09, 1'b1, EXP_PREDICT, 7'h00}
  };

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [15:0] attr_handle;
  logic [7:0]  report_length;
  logic [7:0]  data_byte;
  logic        last_byte;
  logic        out_valid;
  logic        out_stall;
  logic [6:0]  char_code;

  // decoder state
  logic [15:0]       report_handle;
  hidk_pkg::report_t last_report;
  hidk_pkg::report_t report_bytes;
  int                byte_index;
  logic [7:0]        modifier;

  logic [6:0]  char_q [$];
  logic [6:0]  want_char;
  int          mismatch_count;
  int          processed_items;
  bit          tx_idle_on;
  bit          rx_idle_on;
  int          hold_count = 0;
  int          hold_served = 0;

  hid_report_new_key_to_ascii i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .attr_handle   (attr_handle),
    .report_length (report_length),
    .data_byte     (data_byte),
    .last_byte     (last_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .char_code     (char_code)
  );

  always #CLK_HALF clk = ~clk;

  // character table: plain, ctrl and shift columns
  function automatic logic [6:0] key_char(input logic [7:0] mods, input logic [7:0] code);
    logic       shifted;
    logic [6:0] c;
    c = 7'h00;
    shifted = (mods == 8'd2);
    if (mods > 8'd3 || code >= hidk_pkg::KEY_TABLE_CODES) return 7'h00;
    if (mods == 8'd1 || mods == 8'd3) begin
      if (code >= 8'd4 && code <= 8'd29) c = 7'(code - 8'd3);
      return c;
    end
    if (code >= 8'd4 && code <= 8'd29) begin
      c = shifted ? 7'(8'h41 + code - 8'd4) : 7'(8'h61 + code - 8'd4);
      return c;
    end
    case (code)
      8'd30: c = shifted ? 7'h21 : 7'h31;
      8'd31: c = shifted ? 7'h40 : 7'h32;
      8'd32: c = shifted ? 7'h23 : 7'h33;
      8'd33: c = shifted ? 7'h24 : 7'h34;
      8'd34: c = shifted ? 7'h25 : 7'h35;
      8'd35: c = shifted ? 7'h5E : 7'h36;
      8'd36: c = shifted ? 7'h26 : 7'h37;
      8'd37: c = shifted ? 7'h2A : 7'h38;
      8'd38: c = shifted ? 7'h28 : 7'h39;
      8'd39: c = shifted ? 7'h29 : 7'h30;
      8'd40: c = 7'h0D;
      8'd41: c = 7'h1B;
      8'd42: c = 7'h08;
      8'd43: c = 7'h09;
      8'd44: c = 7'h20;
      8'd45: c = shifted ? 7'h5F : 7'h2D;
      8'd46: c = shifted ? 7'h2B : 7'h3D;
      8'd47: c = shifted ? 7'h7B : 7'h5B;
      8'd48: c = shifted ? 7'h7D : 7'h5D;
      8'd49: c = shifted ? 7'h7C : 7'h5C;
      8'd51: c = shifted ? 7'h3A : 7'h3B;
      8'd52: c = shifted ? 7'h22 : 7'h27;
      8'd53: c = shifted ? 7'h7E : 7'h60;
      8'd54: c = shifted ? 7'h3C : 7'h2C;
      8'd55: c = shifted ? 7'h3E : 7'h2E;
      8'd56: c = shifted ? 7'h3F : 7'h2F;
      8'd76: c = 7'h7F;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

  // advance the decoder by one report byte; returns 1 when a character is due
  function automatic logic decode_byte(input logic [15:0] h, input logic [7:0] len,
                                       input logic [7:0] b, input logic last,
                                       output logic [6:0] ch);
    int   first_slot;
    int   slot_count;
    int   pos;
    int   k;
    logic held;
    logic emit;
    ch = 7'h00;
    emit = 1'b0;
    held = 1'b0;
    if (h != report_handle ||
        (len != hidk_pkg::SHORT_REPORT_LEN && len != hidk_pkg::LONG_REPORT_LEN)) begin
      byte_index = 0;
      return 1'b0;
    end
    first_slot = (len == hidk_pkg::LONG_REPORT_LEN) ? 1 : 2;
    slot_count = (len == hidk_pkg::LONG_REPORT_LEN) ? 10 : 6;
    pos = byte_index;
    if (pos < int'(len) && pos < hidk_pkg::MAX_REPORT_BYTES) begin
      report_bytes[pos] = b;
      if (pos == 0) begin
        modifier = b;
      end else if (pos >= first_slot && b != 8'h00) begin
        ch = key_char(modifier, b);
        for (k = first_slot;
             k < first_slot + slot_count && k < hidk_pkg::MAX_REPORT_BYTES; k++)
          if (last_report[k] == b) held = 1'b1;
        emit = (ch != 7'h00) && !held;
      end
      pos++;
    end
    if (last) begin
      for (k = 0; k < pos && k < hidk_pkg::MAX_REPORT_BYTES; k++)
        last_report[k] = report_bytes[k];
      byte_index = 0;
    end else begin
      byte_index = pos;
    end
    return emit;
  endfunction

  task automatic note_error(input string what, input logic [6:0] exp_c,
                            input logic [6:0] act_c);
    mismatch_count++;
    if (mismatch_count <= SHOW_LIMIT)
      $display("%0t ns: %s: expected %02h, got %02h", $time, what, exp_c, act_c);
  endtask

  // offer one report byte and hold it until the transfer
  task automatic send_byte(input logic [15:0] h, input logic [7:0] len,
                           input logic [7:0] b, input logic last,
                           input exp_kind_t kind, input logic [6:0] typed_char);
    logic [6:0] ch;
    logic       emit;
    @(negedge clk);
    while (tx_idle_on && hold_count == hold_served && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    attr_handle   <= h;
    report_length <= len;
    data_byte     <= b;
    last_byte     <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    emit = decode_byte(h, len, b, last, ch);
    case (kind)
      EXP_PREDICT: if (emit) char_q = {char_q, ch};
      EXP_CHAR:    char_q = {char_q, typed_char};
      default:     ;
    endcase
  endtask

  // stop offering bytes and let every due character drain out
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (char_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_handle(input logic [15:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    report_handle = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // key codes biased toward printable keys and keys still held
  function automatic logic [7:0] rand_key();
    int r;
    r = $urandom_range(99);
    if (r < 25) return last_report[$urandom_range(hidk_pkg::MAX_REPORT_BYTES - 1)];
    if (r < 80) return 8'($urandom_range(56, 4));
    if (r < 85) return 8'd76;
    if (r < 90) return 8'h00;
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [7:0] rand_modifier();
    if ($urandom_range(99) < 85) return 8'($urandom_range(3));
    return 8'($urandom_range(255));
  endfunction

  // one random report: mostly well formed, some short, long, foreign or noisy
  task automatic random_report();
    int          kind;
    int          nbytes;
    int          i;
    bit          noisy;
    logic [15:0] h;
    logic [7:0]  len;
    logic [7:0]  l;
    logic [7:0]  b;
    kind  = $urandom_range(99);
    noisy = 1'b0;
    h     = report_handle;
    len   = $urandom_range(1) ? hidk_pkg::LONG_REPORT_LEN : hidk_pkg::SHORT_REPORT_LEN;
    if (kind < 70) begin
      nbytes = len;
    end else if (kind < 80) begin
      nbytes = $urandom_range(len - 1, 1);
    end else if (kind < 87) begin
      nbytes = len + $urandom_range(4, 1);
    end else if (kind < 93) begin
      h = 16'($urandom_range(16'hFFFF));
      if (h == report_handle) h = ~h;
      nbytes = $urandom_range(3, 1);
      if ($urandom_range(1)) len = 8'($urandom_range(255));
    end else begin
      noisy  = 1'b1;
      nbytes = $urandom_range(12, 1);
    end
    for (i = 0; i < nbytes; i++) begin
      l = len;
      if (noisy) begin
        case ($urandom_range(2))
          0:       l = hidk_pkg::SHORT_REPORT_LEN;
          1:       l = hidk_pkg::LONG_REPORT_LEN;
          default: l = 8'($urandom_range(255));
        endcase
      end
      if (i == 0) b = rand_modifier();
      else if (i == 1 && l == hidk_pkg::SHORT_REPORT_LEN) b = 8'($urandom_range(255));
      else b = rand_key();
      send_byte(h, l, b, i == nbytes - 1, EXP_PREDICT, 7'h00);
      if (h == report_handle &&
          (l == hidk_pkg::SHORT_REPORT_LEN || l == hidk_pkg::LONG_REPORT_LEN))
        processed_items++;
    end
  endtask

  // receiver: random stalls, plus long hold-offs on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_count != hold_served) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_served = hold_count;
      end else begin
        out_stall <= rx_idle_on && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // check every character transfer against the oldest due character
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (char_q.size() == 0) begin
        note_error("character with none due", 7'h00, char_code);
      end else begin
        want_char = char_q.pop_front();
        if (char_code !== want_char) note_error("char_code mismatch", want_char, char_code);
      end
    end
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // main sequence
  initial begin
    logic [15:0] phase_handle;
    clk             = 1'b0;
    rst             = 1'b1;
    cfg_valid       = 1'b0;
    cfg_data        = '0;
    in_valid        = 1'b0;
    attr_handle     = '0;
    report_length   = '0;
    data_byte       = '0;
    last_byte       = 1'b0;
    tx_idle_on      = 1'b1;
    rx_idle_on      = 1'b1;
    mismatch_count  = 0;
    processed_items = 0;
    report_handle   = hidk_pkg::HANDLE_RESET;
    last_report     = '0;
    report_bytes    = '0;
    byte_index      = 0;
    modifier        = 8'h00;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table on the reset handle
    for (int r = 0; r < DIR_ROWS; r++)
      send_byte(DIRECTED_ROWS[r].handle, DIRECTED_ROWS[r].len, DIRECTED_ROWS[r].data,
                DIRECTED_ROWS[r].last, DIRECTED_ROWS[r].kind, DIRECTED_ROWS[r].chr);

    // random reports under a series of handle settings
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      case (ph)
        0:       phase_handle = 16'h0000;
        1:       phase_handle = 16'hFFFF;
        3:       phase_handle = hidk_pkg::HANDLE_RESET;
        default: phase_handle = 16'($urandom_range(16'hFFFF));
      endcase
      write_handle(phase_handle);
      // phase one runs without any idling on either side
      tx_idle_on = (ph != 1);
      rx_idle_on = (ph != 1);
      if (ph == 2 || ph == 4) hold_count++;
      while (processed_items < ITEM_TARGET * (ph + 1) / PHASES) random_report();
    end

    wait_idle();
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: hid_report_new_key_to_ascii.f
design/hidk_pkg.sv
design/hidk_key_lookup.sv
design/hid_report_new_key_to_ascii.sv
tb/hid_report_new_key_to_ascii_tb.sv
